// ===== rtl/gtfw_pkg.sv =====
package gtfw_pkg;

	localparam int SCREEN_WIDTH_DEF  = 128;
	localparam int SCREEN_HEIGHT_DEF = 64;

	localparam logic [2:0] OP_CLEAR  = 3'd0;
	localparam logic [2:0] OP_CURSOR = 3'd1;
	localparam logic [2:0] OP_PIXEL  = 3'd2;
	localparam logic [2:0] OP_CHAR   = 3'd3;
	localparam logic [2:0] OP_READ   = 3'd4;

	localparam logic [7:0] GLYPH_COLS   = 8'd5;
	localparam logic [7:0] GLYPH_ROWS   = 8'd7;
	localparam logic [7:0] CHAR_ADVANCE = 8'd6;
	localparam logic [7:0] LINE_ADVANCE = 8'd8;

	typedef logic [6:0] gcol_t;
	typedef gcol_t glyph_t [5];

	typedef struct packed {
		logic [7:0] read_data;
		logic       glyph_drawn;
		logic [7:0] cursor_col;
		logic [7:0] cursor_row;
	} res_t;

	localparam gcol_t DIGIT_ROM [10][5] = '{
		'{7'h3E,7'h51,7'h49,7'h45,7'h3E}, '{7'h00,7'h42,7'h7F,7'h40,7'h00},
		'{7'h42,7'h61,7'h51,7'h49,7'h46}, '{7'h21,7'h41,7'h45,7'h4B,7'h31},
		'{7'h18,7'h14,7'h12,7'h7F,7'h10}, '{7'h27,7'h45,7'h45,7'h45,7'h39},
		'{7'h3C,7'h4A,7'h49,7'h49,7'h30}, '{7'h01,7'h71,7'h09,7'h05,7'h03},
		'{7'h36,7'h49,7'h49,7'h49,7'h36}, '{7'h06,7'h49,7'h49,7'h29,7'h1E}
	};

	localparam gcol_t LETTER_ROM [26][5] = '{
		'{7'h7E,7'h11,7'h11,7'h11,7'h7E}, '{7'h7F,7'h49,7'h49,7'h49,7'h36},
		'{7'h3E,7'h41,7'h41,7'h41,7'h22}, '{7'h7F,7'h41,7'h41,7'h22,7'h1C},
		'{7'h7F,7'h49,7'h49,7'h49,7'h41}, '{7'h7F,7'h09,7'h09,7'h09,7'h01},
		'{7'h3E,7'h41,7'h49,7'h49,7'h7A}, '{7'h7F,7'h08,7'h08,7'h08,7'h7F},
		'{7'h00,7'h41,7'h7F,7'h41,7'h00}, '{7'h20,7'h40,7'h41,7'h3F,7'h01},
		'{7'h7F,7'h08,7'h14,7'h22,7'h41}, '{7'h7F,7'h40,7'h40,7'h40,7'h40},
		'{7'h7F,7'h02,7'h0C,7'h02,7'h7F}, '{7'h7F,7'h04,7'h08,7'h10,7'h7F},
		'{7'h3E,7'h41,7'h41,7'h41,7'h3E}, '{7'h7F,7'h09,7'h09,7'h09,7'h06},
		'{7'h3E,7'h41,7'h51,7'h21,7'h5E}, '{7'h7F,7'h09,7'h19,7'h29,7'h46},
		'{7'h46,7'h49,7'h49,7'h49,7'h31}, '{7'h01,7'h01,7'h7F,7'h01,7'h01},
		'{7'h3F,7'h40,7'h40,7'h40,7'h3F}, '{7'h1F,7'h20,7'h40,7'h20,7'h1F},
		'{7'h3F,7'h40,7'h38,7'h40,7'h3F}, '{7'h63,7'h14,7'h08,7'h14,7'h63},
		'{7'h07,7'h08,7'h70,7'h08,7'h07}, '{7'h61,7'h51,7'h49,7'h45,7'h43}
	};

	localparam gcol_t PERIOD_ROM  [5] = '{7'h00,7'h00,7'h60,7'h60,7'h00};
	localparam gcol_t COLON_ROM   [5] = '{7'h00,7'h00,7'h14,7'h00,7'h00};
	localparam gcol_t DASH_ROM    [5] = '{7'h08,7'h08,7'h08,7'h08,7'h08};
	localparam gcol_t PERCENT_ROM [5] = '{7'h63,7'h13,7'h08,7'h64,7'h63};
	localparam gcol_t BLANK_ROM   [5] = '{7'h00,7'h00,7'h00,7'h00,7'h00};

	function automatic glyph_t glyph_lookup(input logic [7:0] code);
		logic [7:0] c;
		glyph_t g;
		c = code;
		if (c >= 8'h61 && c <= 8'h7A) begin
			c = c - 8'h20;
		end
		if (c >= 8'h30 && c <= 8'h39) begin
			g = DIGIT_ROM[4'(c - 8'h30)];
		end else if (c >= 8'h41 && c <= 8'h5A) begin
			g = LETTER_ROM[5'(c - 8'h41)];
		end else if (c == 8'h2E) begin
			g = PERIOD_ROM;
		end else if (c == 8'h3A) begin
			g = COLON_ROM;
		end else if (c == 8'h2D) begin
			g = DASH_ROM;
		end else if (c == 8'h25) begin
			g = PERCENT_ROM;
		end else begin
			g = BLANK_ROM;
		end
		return g;
	endfunction

endpackage

// ===== rtl/gtfw_frame_ram.sv =====
module gtfw_frame_ram #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);
	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== rtl/gtfw_seq.sv =====
module gtfw_seq #(
	parameter int SCREEN_WIDTH  = 128,
	parameter int SCREEN_HEIGHT = 64,
	parameter int FB_BYTES      = 1024,
	parameter int AW            = 10
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [2:0]    op,
	input  logic [7:0]    coord_x,
	input  logic [7:0]    coord_y,
	input  logic          pixel_on,
	input  logic [7:0]    char_code,
	input  logic [9:0]    byte_address,
	output logic          fin_valid,
	input  logic          fin_taken,
	output gtfw_pkg::res_t fin_res,
	output logic          we,
	output logic [AW-1:0] waddr,
	output logic [7:0]    wdata,
	output logic          re,
	output logic [AW-1:0] raddr,
	input  logic [7:0]    rdata
);
	import gtfw_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CLR  = 3'd1;
	localparam logic [2:0] S_RD   = 3'd2;
	localparam logic [2:0] S_WR   = 3'd3;
	localparam logic [2:0] S_RDB  = 3'd4;
	localparam logic [2:0] S_CAP  = 3'd5;
	localparam logic [2:0] S_FIN  = 3'd6;

	logic [2:0]    state_q;
	logic [AW-1:0] cnt_q;
	logic [3:0]    k_q;
	logic          is_glyph_q;
	logic          clr_rsp_q;
	logic [7:0]    col_q, row_q;
	logic [7:0]    rd_q;
	logic          drawn_q;
	glyph_t        gl_q;
	logic [AW-1:0] paddr_q;
	logic [7:0]    pmask_q, pdata_q;
	logic [AW-1:0] baddr_q;

	logic          take;
	logic [8:0]    col_sum, row_sum;
	logic          wrap;
	logic [7:0]    ncol, nrow;
	logic [AW:0]   gaddr;
	logic [14:0]   gdat16, gmask16;
	logic [AW-1:0] cur_addr;
	logic [7:0]    cur_mask, cur_data;

	assign in_ready  = (state_q == S_IDLE);
	assign take      = in_valid && in_ready;
	assign fin_valid = (state_q == S_FIN);
	assign fin_res   = '{read_data: rd_q, glyph_drawn: drawn_q,
		cursor_col: col_q, cursor_row: row_q};

	// wrap check on the cursor before a glyph
	assign col_sum = {1'b0, col_q} + {1'b0, GLYPH_COLS};
	assign wrap    = col_sum >= 9'(SCREEN_WIDTH);
	assign ncol    = wrap ? 8'd0 : col_q;
	assign nrow    = wrap ? row_q + LINE_ADVANCE : row_q;
	assign row_sum = {1'b0, nrow} + {1'b0, GLYPH_ROWS};

	// glyph step: column k/2, upper or lower page by k%2
	always_comb begin
		gdat16  = 15'({8'd0, gl_q[k_q[3:1]]} << row_q[2:0]);
		gmask16 = 15'(15'h7F << row_q[2:0]);
		gaddr   = (AW+1)'(col_q) + (AW+1)'(k_q[3:1])
			+ (AW+1)'(row_q[7:3] + 5'(k_q[0])) * (AW+1)'(SCREEN_WIDTH);
		if (is_glyph_q) begin
			cur_addr = AW'(gaddr);
			cur_mask = k_q[0] ? {1'b0, gmask16[14:8]} : gmask16[7:0];
			cur_data = k_q[0] ? {1'b0, gdat16[14:8]} : gdat16[7:0];
		end else begin
			cur_addr = paddr_q;
			cur_mask = pmask_q;
			cur_data = pdata_q;
		end
	end

	always_comb begin
		we    = 1'b0;
		waddr = cur_addr;
		wdata = (rdata & ~cur_mask) | (cur_data & cur_mask);
		re    = 1'b0;
		raddr = cur_addr;
		unique case (state_q)
			S_CLR: begin
				we    = 1'b1;
				waddr = cnt_q;
				wdata = 8'd0;
			end
			S_RD: re = 1'b1;
			S_WR: we = (cur_mask != 8'd0);
			S_RDB: begin
				re    = 1'b1;
				raddr = baddr_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			cnt_q     <= '0;
			col_q     <= '0;
			row_q     <= '0;
			k_q       <= '0;
			clr_rsp_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (take) begin
					rd_q       <= 8'd0;
					drawn_q    <= 1'b0;
					is_glyph_q <= 1'b0;
					clr_rsp_q  <= 1'b0;
					k_q        <= '0;
					gl_q       <= glyph_lookup(char_code);
					paddr_q    <= AW'((AW+1)'(coord_x)
						+ (AW+1)'(coord_y[7:3]) * (AW+1)'(SCREEN_WIDTH));
					pmask_q    <= 8'(8'd1 << coord_y[2:0]);
					pdata_q    <= pixel_on ? 8'(8'd1 << coord_y[2:0]) : 8'd0;
					baddr_q    <= AW'(byte_address);
					state_q    <= S_FIN;
					unique case (op)
						OP_CLEAR: begin
							col_q     <= '0;
							row_q     <= '0;
							cnt_q     <= '0;
							clr_rsp_q <= 1'b1;
							state_q   <= S_CLR;
						end
						OP_CURSOR: begin
							col_q <= coord_x;
							row_q <= coord_y;
						end
						OP_PIXEL: if ({1'b0, coord_x} < 9'(SCREEN_WIDTH)
								&& {1'b0, coord_y} < 9'(SCREEN_HEIGHT)) begin
							state_q <= S_RD;
						end
						OP_CHAR: begin
							col_q <= ncol;
							row_q <= nrow;
							if (row_sum < 9'(SCREEN_HEIGHT)) begin
								is_glyph_q <= 1'b1;
								state_q    <= S_RD;
							end
						end
						OP_READ: if ({2'b0, byte_address} < 12'(FB_BYTES)) begin
							state_q <= S_RDB;
						end
						default: ;
					endcase
				end
				S_CLR: begin
					cnt_q <= cnt_q + AW'(1);
					if (cnt_q == AW'(FB_BYTES - 1)) begin
						// the pass after reset has no transaction to answer
						state_q <= clr_rsp_q ? S_FIN : S_IDLE;
					end
				end
				S_RD: state_q <= S_WR;
				S_WR: begin
					if (is_glyph_q && k_q != 4'd9) begin
						k_q     <= k_q + 4'd1;
						state_q <= S_RD;
					end else begin
						if (is_glyph_q) begin
							col_q   <= col_q + CHAR_ADVANCE;
							drawn_q <= 1'b1;
						end
						state_q <= S_FIN;
					end
				end
				S_RDB: state_q <= S_CAP;
				S_CAP: begin
					rd_q    <= rdata;
					state_q <= S_FIN;
				end
				S_FIN: if (fin_taken) begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/glyph_text_framebuffer_writer_unit.sv =====
// monochrome page framebuffer with a 5x7 text renderer
// input channel (in_valid/in_ready): one operation per transaction, op selects
//   clear, set cursor, draw pixel, write char or read byte
// output channel (out_valid/out_ready): exactly one result transaction per input
//   transaction, carrying read_data, glyph_drawn and the cursor after the op
// one operation is in flight at a time; each op works through the frame memory,
//   which has one write port and one registered read port:
//   set cursor, skipped pixel or glyph, unused op: straight to the result
//   read byte: a read and a capture; draw pixel: one read-modify-write step
//   write char: ten read-modify-write steps, one per glyph column and page
//   clear: one memory byte zeroed per cycle
// a result sits in the output register while the next op is already accepted
//   and worked on; that op waits at its end until the register is free
// reset: cursor goes to zero and a clearing pass writes every frame byte to
//   zero (FB_BYTES of them, 1024 by default), with in_ready low
// when the receiver stalls the result holds and the block stops after at most
//   one further accepted op
module glyph_text_framebuffer_writer_unit #(
	parameter int SCREEN_WIDTH  = gtfw_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = gtfw_pkg::SCREEN_HEIGHT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] op,
	input  logic [7:0] coord_x,
	input  logic [7:0] coord_y,
	input  logic       pixel_on,
	input  logic [7:0] char_code,
	input  logic [9:0] byte_address,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] read_data,
	output logic       glyph_drawn,
	output logic [7:0] cursor_col,
	output logic [7:0] cursor_row
);
	import gtfw_pkg::*;

	// pages of eight rows, one byte per column per page
	localparam int PAGE_COUNT = (SCREEN_HEIGHT + 7) / 8;
	localparam int FB_BYTES   = SCREEN_WIDTH * PAGE_COUNT;
	localparam int AW         = $clog2(FB_BYTES);

	logic          fin_valid;
	logic          fin_taken;
	res_t          fin_res;
	res_t          res_q;
	logic          ov_q;
	logic          we, re;
	logic [AW-1:0] waddr, raddr;
	logic [7:0]    wdata, rdata;

	// output slot frees when empty or being taken this cycle
	assign fin_taken = !ov_q || out_ready;

	gtfw_seq #(
		.SCREEN_WIDTH (SCREEN_WIDTH),
		.SCREEN_HEIGHT(SCREEN_HEIGHT),
		.FB_BYTES     (FB_BYTES),
		.AW           (AW)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.coord_x     (coord_x),
		.coord_y     (coord_y),
		.pixel_on    (pixel_on),
		.char_code   (char_code),
		.byte_address(byte_address),
		.fin_valid   (fin_valid),
		.fin_taken   (fin_taken),
		.fin_res     (fin_res),
		.we          (we),
		.waddr       (waddr),
		.wdata       (wdata),
		.re          (re),
		.raddr       (raddr),
		.rdata       (rdata)
	);

	gtfw_frame_ram #(
		.DEPTH(FB_BYTES),
		.AW   (AW)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (fin_valid && fin_taken) begin
			ov_q <= 1'b1;
		end else if (out_ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_valid && fin_taken) begin
			res_q <= fin_res;
		end
	end

	assign out_valid   = ov_q;
	assign read_data   = res_q.read_data;
	assign glyph_drawn = res_q.glyph_drawn;
	assign cursor_col  = res_q.cursor_col;
	assign cursor_row  = res_q.cursor_row;
endmodule

// ===== rtl/gtfw_checker.sv =====
module gtfw_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] read_data,
	input logic       glyph_drawn
);
	// one operation at a time
	a_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("accepted a second op back to back");

	// a drawn glyph never reports read data
	a_drawn_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && glyph_drawn |-> read_data == 8'd0)
		else $error("glyph result with read data");

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_data)
		&& $stable(glyph_drawn))
		else $error("stalled result changed");
endmodule

bind glyph_text_framebuffer_writer_unit gtfw_checker u_gtfw_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.read_data  (read_data),
	.glyph_drawn(glyph_drawn)
);
